/* sv/tfsf_pkg.sv */
// tfsf_pkg: shared types, codes and reset values for the touch frame stability filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tfsf_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned RawBits      = 12;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 16;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] REG_INT_GATE_MS     = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_SCREEN_WIDTH    = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_SCREEN_HEIGHT   = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_ORIENTATION     = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_JITTER_LIMIT    = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_PRESS_THRESH    = 3'd5;
  localparam logic [CfgIdxBits-1:0] REG_RELEASE_THRESH  = 3'd6;

  // frame classes
  localparam logic [1:0] CLS_EMPTY   = 2'd0;
  localparam logic [1:0] CLS_FINGER  = 2'd1;
  localparam logic [1:0] CLS_GARBAGE = 2'd2;

  localparam logic [RawBits-1:0] RAW_X_MAX   = 12'd239;
  localparam logic [RawBits-1:0] RAW_Y_MAX   = 12'd319;
  localparam logic [7:0]         MAX_FINGERS = 8'd2;
  localparam logic [7:0]         CNT_MAX     = 8'hFF;

  localparam logic [15:0] RST_INT_GATE_MS    = 16'd100;
  localparam logic [12:0] RST_SCREEN_WIDTH   = 13'd240;
  localparam logic [12:0] RST_SCREEN_HEIGHT  = 13'd320;
  localparam logic [2:0]  RST_ORIENTATION    = 3'd0;
  localparam logic [11:0] RST_JITTER_LIMIT   = 12'd40;
  localparam logic [7:0]  RST_PRESS_THRESH   = 8'd3;
  localparam logic [7:0]  RST_RELEASE_THRESH = 8'd3;

  typedef struct packed {
    logic [15:0] int_gate_ms;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [2:0]  orientation;
    logic [11:0] jitter_limit;
    logic [7:0]  press_thresh;
    logic [7:0]  release_thresh;
  } cfg_t;

  typedef struct packed {
    logic        read_ok;
    logic [7:0]  finger_count;
    logic [7:0]  x_high;
    logic [7:0]  x_low;
    logic [7:0]  y_high;
    logic [7:0]  y_low;
    logic [31:0] now_ms;
    logic [31:0] last_int_ms;
    logic        int_seen;
  } frame_t;

  typedef struct packed {
    logic       pressed;
    logic [1:0] frame_class;
  } status_t;

endpackage

`default_nettype wire

/* sv/tfsf_frame_if.sv */
// tfsf_frame_if: valid/ready channel carrying one polled touch frame
// depends on tfsf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tfsf_frame_if
  import tfsf_pkg::*;
();
  logic        valid;
  logic        ready;
  logic        read_ok;
  logic [7:0]  finger_count;
  logic [7:0]  x_high;
  logic [7:0]  x_low;
  logic [7:0]  y_high;
  logic [7:0]  y_low;
  logic [31:0] now_ms;
  logic [31:0] last_int_ms;
  logic        int_seen;

  modport source (
    output valid, read_ok, finger_count, x_high, x_low, y_high, y_low,
           now_ms, last_int_ms, int_seen,
    input  ready
  );

  modport sink (
    input  valid, read_ok, finger_count, x_high, x_low, y_high, y_low,
           now_ms, last_int_ms, int_seen,
    output ready
  );
endinterface

`default_nettype wire

/* sv/tfsf_result_if.sv */
// tfsf_result_if: valid/ready channel carrying one filtered touch result
// depends on tfsf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tfsf_result_if
  import tfsf_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) ();
  logic                  valid;
  logic                  ready;
  logic                  pressed;
  logic [COORD_BITS-1:0] touch_x;
  logic [COORD_BITS-1:0] touch_y;
  logic [1:0]            frame_class;

  modport source (
    output valid, pressed, touch_x, touch_y, frame_class,
    input  ready
  );

  modport sink (
    input  valid, pressed, touch_x, touch_y, frame_class,
    output ready
  );
endinterface

`default_nettype wire

/* sv/tfsf_filter.sv */
// tfsf_filter: frame classification, orientation, clamp and press/release state
// depends on tfsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfsf_filter
  import tfsf_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire frame_t                frame_i,
  input  wire cfg_t                  cfg_i,
  output status_t                    status_o,
  output logic     [COORD_BITS-1:0]  touch_x_o,
  output logic     [COORD_BITS-1:0]  touch_y_o
);

  localparam int unsigned CmpW = (COORD_BITS > RawBits) ? COORD_BITS : RawBits;
  localparam int unsigned SW   = CmpW + 2;
  localparam int unsigned SzW  = COORD_BITS + 1;
  localparam int unsigned ExtW = 18;
  localparam logic [SzW-1:0] SizeLim = {1'b1, {COORD_BITS{1'b0}}};

  function automatic logic [SzW-1:0] eff_size(input logic [12:0] s);
    logic [ExtW-1:0] v;
    v = ExtW'(s);
    if (s == 13'd0) v = ExtW'(1);
    if (v > ExtW'(SizeLim)) v = ExtW'(SizeLim);
    return SzW'(v);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_to(
    input logic signed [SW-1:0] v,
    input logic signed [SW-1:0] sz
  );
    logic signed [SW-1:0] top;
    top = sz - SW'(1);
    if (v < 0) return '0;
    if (v > top) return COORD_BITS'(top);
    return COORD_BITS'(v);
  endfunction

  logic                  stable_down_q, stable_down_d;
  logic [7:0]            press_count_q, press_count_d;
  logic [7:0]            release_count_q, release_count_d;
  logic [COORD_BITS-1:0] last_x_q, last_x_d;
  logic [COORD_BITS-1:0] last_y_q, last_y_d;
  logic                  gate_armed_q, gate_armed_d;

  logic [RawBits-1:0]    raw_x, raw_y, sel_x, sel_y;
  logic [1:0]            cls;
  logic [31:0]           elapsed;
  logic signed [SW-1:0]  w_s, h_s, xs, ys;
  logic [COORD_BITS-1:0] cx, cy, dx, dy;
  logic                  jitter;

  assign raw_x   = {frame_i.x_high[3:0], frame_i.x_low};
  assign raw_y   = {frame_i.y_high[3:0], frame_i.y_low};
  assign elapsed = frame_i.now_ms - frame_i.last_int_ms;
  assign gate_armed_d = gate_armed_q | frame_i.int_seen;

  always_comb begin
    if (!frame_i.read_ok) begin
      cls = CLS_GARBAGE;
    end else if (frame_i.finger_count == 8'd0) begin
      cls = CLS_EMPTY;
    end else if (frame_i.finger_count > MAX_FINGERS) begin
      cls = CLS_GARBAGE;
    end else if (raw_x > RAW_X_MAX || raw_y > RAW_Y_MAX) begin
      cls = CLS_GARBAGE;
    end else begin
      cls = CLS_FINGER;
    end
    if (gate_armed_d && cls == CLS_FINGER && elapsed > {16'd0, cfg_i.int_gate_ms}) begin
      cls = CLS_EMPTY;
    end
  end

  // orientation, clamp and jitter check
  always_comb begin
    w_s   = $signed(SW'(eff_size(cfg_i.screen_width)));
    h_s   = $signed(SW'(eff_size(cfg_i.screen_height)));
    sel_x = cfg_i.orientation[0] ? raw_y : raw_x;
    sel_y = cfg_i.orientation[0] ? raw_x : raw_y;
    xs    = $signed(SW'(sel_x));
    ys    = $signed(SW'(sel_y));
    if (cfg_i.orientation[1]) xs = w_s - SW'(1) - xs;
    if (cfg_i.orientation[2]) ys = h_s - SW'(1) - ys;
    cx = clamp_to(xs, w_s);
    cy = clamp_to(ys, h_s);
    dx = (cx > last_x_q) ? cx - last_x_q : last_x_q - cx;
    dy = (cy > last_y_q) ? cy - last_y_q : last_y_q - cy;
    jitter = (CmpW'(dx) > CmpW'(cfg_i.jitter_limit)) ||
             (CmpW'(dy) > CmpW'(cfg_i.jitter_limit));
  end

  always_comb begin
    stable_down_d   = stable_down_q;
    press_count_d   = press_count_q;
    release_count_d = release_count_q;
    last_x_d        = last_x_q;
    last_y_d        = last_y_q;
    case (cls)
      CLS_FINGER: begin
        release_count_d = 8'd0;
        if (!stable_down_q && press_count_q != 8'd0 && jitter) begin
          press_count_d = 8'd1;
        end else if (press_count_q != CNT_MAX) begin
          press_count_d = press_count_q + 8'd1;
        end
        last_x_d = cx;
        last_y_d = cy;
        if (press_count_d >= cfg_i.press_thresh) stable_down_d = 1'b1;
      end
      CLS_EMPTY: begin
        press_count_d = 8'd0;
        if (release_count_q != CNT_MAX) release_count_d = release_count_q + 8'd1;
        if (release_count_d >= cfg_i.release_thresh) stable_down_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign status_o.pressed     = stable_down_d;
  assign status_o.frame_class = cls;
  assign touch_x_o = stable_down_d ? last_x_d : '0;
  assign touch_y_o = stable_down_d ? last_y_d : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_down_q   <= 1'b0;
      press_count_q   <= 8'd0;
      release_count_q <= 8'd0;
      last_x_q        <= '0;
      last_y_q        <= '0;
      gate_armed_q    <= 1'b0;
    end else if (step_i) begin
      stable_down_q   <= stable_down_d;
      press_count_q   <= press_count_d;
      release_count_q <= release_count_d;
      last_x_q        <= last_x_d;
      last_y_q        <= last_y_d;
      gate_armed_q    <= gate_armed_d;
    end
  end

  a_gate_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(gate_armed_q))
    else $error("interrupt gate disarmed");

  a_garbage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && cls == CLS_GARBAGE |=> $stable(press_count_q) && $stable(release_count_q)
      && $stable(stable_down_q))
    else $error("garbage frame changed press state");

  a_finger_clears_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && cls == CLS_FINGER |=> release_count_q == 8'd0 && press_count_q != 8'd0)
    else $error("finger frame left release count");

  a_empty_clears_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && cls == CLS_EMPTY |=> press_count_q == 8'd0 && release_count_q != 8'd0)
    else $error("empty frame left press count");

endmodule

`default_nettype wire

/* sv/touch_frame_stability_filter_top.sv */
// touch_frame_stability_filter_top: input register, filter logic, result register
// an accepted frame is held in the input register; its filtered result is held in the result register
// throughput: one frame per cycle while results are taken; the input stage refills while the result stage drains
// reset: press/release counters, coordinates and gate clear; config registers take default values
// depends on tfsf_pkg, tfsf_frame_if, tfsf_result_if, tfsf_filter
`timescale 1ns / 1ps
`default_nettype none

module touch_frame_stability_filter_top
  import tfsf_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_wdata_i,
  tfsf_frame_if.sink                  frame_i,
  tfsf_result_if.source               result_o
);

  cfg_t                  cfg_q;
  frame_t                frame_q;
  logic                  in_valid_q;
  logic                  out_valid_q;
  status_t               status_q;
  logic [COORD_BITS-1:0] touch_x_q, touch_y_q;

  status_t               status_d;
  logic [COORD_BITS-1:0] touch_x_d, touch_y_d;
  logic                  advance, in_accept;

  assign advance        = in_valid_q && (!out_valid_q || result_o.ready);
  assign frame_i.ready  = !in_valid_q || advance;
  assign in_accept      = frame_i.valid && frame_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.int_gate_ms    <= RST_INT_GATE_MS;
      cfg_q.screen_width   <= RST_SCREEN_WIDTH;
      cfg_q.screen_height  <= RST_SCREEN_HEIGHT;
      cfg_q.orientation    <= RST_ORIENTATION;
      cfg_q.jitter_limit   <= RST_JITTER_LIMIT;
      cfg_q.press_thresh   <= RST_PRESS_THRESH;
      cfg_q.release_thresh <= RST_RELEASE_THRESH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INT_GATE_MS:    cfg_q.int_gate_ms    <= cfg_wdata_i[15:0];
        REG_SCREEN_WIDTH:   cfg_q.screen_width   <= cfg_wdata_i[12:0];
        REG_SCREEN_HEIGHT:  cfg_q.screen_height  <= cfg_wdata_i[12:0];
        REG_ORIENTATION:    cfg_q.orientation    <= cfg_wdata_i[2:0];
        REG_JITTER_LIMIT:   cfg_q.jitter_limit   <= cfg_wdata_i[11:0];
        REG_PRESS_THRESH:   cfg_q.press_thresh   <= cfg_wdata_i[7:0];
        REG_RELEASE_THRESH: cfg_q.release_thresh <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      frame_q.read_ok      <= frame_i.read_ok;
      frame_q.finger_count <= frame_i.finger_count;
      frame_q.x_high       <= frame_i.x_high;
      frame_q.x_low        <= frame_i.x_low;
      frame_q.y_high       <= frame_i.y_high;
      frame_q.y_low        <= frame_i.y_low;
      frame_q.now_ms       <= frame_i.now_ms;
      frame_q.last_int_ms  <= frame_i.last_int_ms;
      frame_q.int_seen     <= frame_i.int_seen;
    end
  end

  tfsf_filter #(
    .COORD_BITS (COORD_BITS)
  ) u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .frame_i   (frame_q),
    .cfg_i     (cfg_q),
    .status_o  (status_d),
    .touch_x_o (touch_x_d),
    .touch_y_o (touch_y_d)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q  <= status_d;
      touch_x_q <= touch_x_d;
      touch_y_q <= touch_y_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.pressed     = status_q.pressed;
  assign result_o.touch_x     = touch_x_q;
  assign result_o.touch_y     = touch_y_q;
  assign result_o.frame_class = status_q.frame_class;

endmodule

`default_nettype wire
